// File: src/hsmr_pkg.sv
// ----------------------------------------------------------------------------
// hsmr_pkg
// Shared types and constants for the hall-encoder motor run controller.
// ----------------------------------------------------------------------------
package hsmr_pkg;

  localparam int MAX_TEST_TRIES_DEF = 5;
  localparam int DUTY_BITS_DEF      = 10;

  localparam int CMD_W      = 4;
  localparam int STEP_W     = 32;
  localparam int TENTHS_W   = 12;
  localparam int FREQ_W     = 17;
  localparam int DUTY_OUT_W = 10;
  localparam int TRIES_W    = 4;
  localparam int TMR_W      = 2;

  localparam logic [TENTHS_W-1:0] DUTY_TENTHS_MAX  = 12'd1000;
  localparam int                  TEST_DUTY_TENTHS = 100;
  localparam logic [FREQ_W-1:0]   TEST_FREQ_HZ     = 17'd100;
  localparam logic [TRIES_W-1:0]  TRIES_CAP        = 4'd15;

  typedef enum logic [CMD_W-1:0] {
    CMD_START          = 4'd0,
    CMD_START_STEPS    = 4'd1,
    CMD_STOP           = 4'd2,
    CMD_TEST           = 4'd3,
    CMD_ENCODER_PULSE  = 4'd4,
    CMD_FAULT_LEVEL    = 4'd5,
    CMD_TEST_TIMEOUT   = 4'd6,
    CMD_ALIVE_LOST     = 4'd7,
    CMD_REPORT_TIMEOUT = 4'd8
  } cmd_t;

  typedef enum logic [TMR_W-1:0] {
    TMR_NONE  = 2'd0,
    TMR_50MS  = 2'd1,
    TMR_100MS = 2'd2
  } tmr_req_t;

  typedef struct packed {
    logic [CMD_W-1:0]    cmd;
    logic [STEP_W-1:0]   step_target;
    logic [TENTHS_W-1:0] duty_tenths;
    logic [FREQ_W-1:0]   pwm_freq;
    logic                fault_low;
  } hsmr_evt_t;

  typedef struct packed {
    logic                  status_report;
    logic                  running;
    logic                  power_enable;
    logic [DUTY_OUT_W-1:0] duty_code;
    logic [FREQ_W-1:0]     freq_out;
    logic [STEP_W-1:0]     step_count;
    logic                  fault_active;
    logic                  test_ok;
    logic [TMR_W-1:0]      test_timer_req;
    logic                  overshoot_timer_start;
  } hsmr_res_t;

endpackage

// File: src/hsmr_duty.sv
// ----------------------------------------------------------------------------
// hsmr_duty
// Tenths-of-percent to PWM code: clamp, then (2^DUTY_BITS-1)*t/1000 split as
// a*t + (b*t)/1000, the division done by a reciprocal multiply.
// ----------------------------------------------------------------------------
module hsmr_duty
  import hsmr_pkg::*;
#(
  parameter int DUTY_BITS = DUTY_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 load,
  input  logic [TENTHS_W-1:0]  duty_tenths,
  output logic [DUTY_BITS-1:0] duty
);

  localparam int MAXD  = (1 << DUTY_BITS) - 1;
  localparam int QUO   = MAXD / 1000;
  localparam int REM   = MAXD % 1000;
  localparam int PW    = DUTY_BITS + 10;
  // exact for products below 2^20
  localparam int RSH   = 30;
  localparam int RMUL  = ((1 << RSH) + 999) / 1000;

  logic [9:0]  t;
  logic [19:0] x;
  logic [9:0]  t_q;
  logic [19:0] x_q;
  logic [40:0] prod;
  logic [PW-1:0] hi;

  assign t = (duty_tenths > DUTY_TENTHS_MAX) ? DUTY_TENTHS_MAX[9:0] : duty_tenths[9:0];
  assign x = 20'(REM) * 20'(t);

  always_ff @(posedge clk) begin
    if (load) begin
      t_q <= t;
      x_q <= x;
    end
  end

  assign prod = 41'(x_q) * 41'(RMUL);
  assign hi   = PW'(QUO) * PW'(t_q);
  assign duty = DUTY_BITS'(hi + PW'(prod[RSH+9:RSH]));

endmodule

// File: src/hsmr_core.sv
// ----------------------------------------------------------------------------
// hsmr_core
// Run / stop / test state and event decode; one event per load.
// ----------------------------------------------------------------------------
module hsmr_core
  import hsmr_pkg::*;
#(
  parameter int MAX_TEST_TRIES = MAX_TEST_TRIES_DEF,
  parameter int DUTY_BITS      = DUTY_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  hsmr_evt_t            evt,
  input  logic [DUTY_BITS-1:0] duty_req,
  output hsmr_res_t            res
);

  localparam logic [DUTY_BITS-1:0] TEST_DUTY =
    DUTY_BITS'(((1 << DUTY_BITS) - 1) * TEST_DUTY_TENTHS / 1000);
  localparam logic [TRIES_W-1:0] MAX_TRIES = TRIES_W'(MAX_TEST_TRIES);

  logic                  run_flag,     run_flag_next;
  logic                  limit_mode,   limit_mode_next;
  logic [STEP_W-1:0]     target_steps, target_steps_next;
  logic [STEP_W-1:0]     pulse_count,  pulse_count_next;
  logic [DUTY_OUT_W-1:0] duty_setting, duty_setting_next;
  logic [FREQ_W-1:0]     freq_setting, freq_setting_next;
  logic                  fault_flag,   fault_flag_next;
  logic                  test_active,  test_active_next;
  logic [TRIES_W-1:0]    test_tries,   test_tries_next;

  logic                  rep;
  logic                  overshoot;
  tmr_req_t              tmr;
  logic [STEP_W-1:0]     cnt_inc;
  logic [DUTY_OUT_W-1:0] duty_low;
  logic [DUTY_OUT_W-1:0] test_duty_low;
  logic [DUTY_BITS+DUTY_OUT_W-1:0] duty_ext;
  logic [DUTY_BITS+DUTY_OUT_W-1:0] test_ext;

  // low 10 bits of the code, zero-extended when DUTY_BITS is narrower
  assign duty_ext      = {{DUTY_OUT_W{1'b0}}, duty_req};
  assign test_ext      = {{DUTY_OUT_W{1'b0}}, TEST_DUTY};
  assign duty_low      = duty_ext[DUTY_OUT_W-1:0];
  assign test_duty_low = test_ext[DUTY_OUT_W-1:0];
  assign cnt_inc       = pulse_count + 1'b1;

  always_comb begin
    run_flag_next     = run_flag;
    limit_mode_next   = limit_mode;
    target_steps_next = target_steps;
    pulse_count_next  = pulse_count;
    duty_setting_next = duty_setting;
    freq_setting_next = freq_setting;
    fault_flag_next   = fault_flag;
    test_active_next  = test_active;
    test_tries_next   = test_tries;
    rep               = 1'b0;
    overshoot         = 1'b0;
    tmr               = TMR_NONE;

    unique case (cmd_t'(evt.cmd))
      CMD_START, CMD_START_STEPS: begin
        if (cmd_t'(evt.cmd) == CMD_START_STEPS) begin
          target_steps_next = evt.step_target;
        end
        duty_setting_next = duty_low;
        freq_setting_next = evt.pwm_freq;
        limit_mode_next   = (cmd_t'(evt.cmd) == CMD_START_STEPS);
        pulse_count_next  = '0;
        run_flag_next     = 1'b1;
        rep               = 1'b1;
      end
      CMD_STOP: begin
        run_flag_next = 1'b0;
        rep           = 1'b1;
        overshoot     = 1'b1;
      end
      CMD_TEST: begin
        if (!test_active) begin
          pulse_count_next = '0;
          test_tries_next  = '0;
          tmr              = TMR_50MS;
        end
      end
      CMD_ENCODER_PULSE: begin
        pulse_count_next = cnt_inc;
        if (run_flag && limit_mode && (cnt_inc >= target_steps)) begin
          run_flag_next = 1'b0;
          rep           = 1'b1;
          overshoot     = 1'b1;
        end
      end
      CMD_FAULT_LEVEL: begin
        if (evt.fault_low != fault_flag) begin
          fault_flag_next = evt.fault_low;
          rep             = 1'b1;
        end
      end
      CMD_TEST_TIMEOUT: begin
        priority if (test_active) begin
          // end of a test run: halt; retry if no pulse was seen, else report
          test_active_next = 1'b0;
          run_flag_next    = 1'b0;
          overshoot        = 1'b1;
          if (pulse_count == '0) begin
            tmr = TMR_100MS;
          end else begin
            rep = 1'b1;
          end
        end else if (pulse_count != '0) begin
          rep = 1'b1;
        end else if (test_tries < MAX_TRIES) begin
          tmr               = TMR_50MS;
          test_active_next  = 1'b1;
          duty_setting_next = test_duty_low;
          freq_setting_next = TEST_FREQ_HZ;
          limit_mode_next   = 1'b0;
          pulse_count_next  = '0;
          run_flag_next     = 1'b1;
          test_tries_next   = test_tries + 1'b1;
        end else begin
          if (test_tries < TRIES_CAP) begin
            test_tries_next = test_tries + 1'b1;
          end
          rep = 1'b1;
        end
      end
      CMD_ALIVE_LOST: begin
        run_flag_next = 1'b0;
        overshoot     = 1'b1;
      end
      CMD_REPORT_TIMEOUT: begin
        rep = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_flag     <= 1'b0;
      limit_mode   <= 1'b0;
      target_steps <= '0;
      pulse_count  <= '0;
      duty_setting <= '0;
      freq_setting <= '0;
      fault_flag   <= 1'b0;
      test_active  <= 1'b0;
      test_tries   <= '0;
    end else if (load) begin
      run_flag     <= run_flag_next;
      limit_mode   <= limit_mode_next;
      target_steps <= target_steps_next;
      pulse_count  <= pulse_count_next;
      duty_setting <= duty_setting_next;
      freq_setting <= freq_setting_next;
      fault_flag   <= fault_flag_next;
      test_active  <= test_active_next;
      test_tries   <= test_tries_next;
    end
  end

  always_comb begin
    res.status_report         = rep;
    res.running               = run_flag_next;
    res.power_enable          = run_flag_next;
    res.duty_code             = run_flag_next ? duty_setting_next : '0;
    res.freq_out              = freq_setting_next;
    res.step_count            = pulse_count_next;
    res.fault_active          = fault_flag_next;
    res.test_ok               = (test_tries_next < MAX_TRIES);
    res.test_timer_req        = tmr;
    res.overshoot_timer_start = overshoot;
  end

endmodule

// File: src/hall_step_motor_run_controller.sv
// ----------------------------------------------------------------------------
// hall_step_motor_run_controller
// Hall-encoder DC motor run controller: start/stop/test events, step counting,
// fault tracking, one status result per request.
// ----------------------------------------------------------------------------
// Pipeline: input register at the accept edge, then state update into the result
//   register. Throughput: one request per cycle while no result is stalled; the
//   remainder product is formed ahead of the input register, the reciprocal
//   multiply and state update after it.
// Reset (rst, synchronous): all motor/test state cleared, pipeline emptied.
module hall_step_motor_run_controller
  import hsmr_pkg::*;
#(
  parameter int MAX_TEST_TRIES = MAX_TEST_TRIES_DEF,
  parameter int DUTY_BITS      = DUTY_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      evt_valid,
  output logic      evt_ready,
  input  hsmr_evt_t evt,
  output logic      res_valid,
  input  logic      res_ready,
  output hsmr_res_t res
);

  logic                 s1_valid;
  hsmr_evt_t            s1_evt;
  logic                 advance;
  logic                 accept;
  logic [DUTY_BITS-1:0] duty_req;
  hsmr_res_t            res_next;

  assign advance   = !res_valid || res_ready;
  assign evt_ready = !s1_valid || advance;
  assign accept    = evt_valid && evt_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (evt_ready) begin
        s1_valid <= evt_valid;
      end
      if (advance) begin
        res_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_evt <= evt;
    end
    if (advance && s1_valid) begin
      res <= res_next;
    end
  end

  hsmr_duty #(
    .DUTY_BITS(DUTY_BITS)
  ) u_duty (
    .clk        (clk),
    .load       (accept),
    .duty_tenths(evt.duty_tenths),
    .duty       (duty_req)
  );

  hsmr_core #(
    .MAX_TEST_TRIES(MAX_TEST_TRIES),
    .DUTY_BITS     (DUTY_BITS)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .load    (advance && s1_valid),
    .evt     (s1_evt),
    .duty_req(duty_req),
    .res     (res_next)
  );

endmodule
